// File: sv/adc_parallel_read_sequencer_unit_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef ADC_PARALLEL_READ_SEQUENCER_UNIT_MACROS_SVH
`define ADC_PARALLEL_READ_SEQUENCER_UNIT_MACROS_SVH

// The property must hold in the same cycle as its trigger.
`define APRS_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// The property must hold in the cycle after its trigger.
`define APRS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// File: sv/aprs_pkg.sv
package aprs_pkg;

   localparam int DATA_W    = 16;
   localparam int TICK_W    = 10;
   localparam int CH_W      = 3;
   localparam int OS_W      = 3;
   localparam int CSR_IDX_W = 3;

   localparam logic [OS_W-1:0] OS_CODE_INVALID = 3'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONVERT_PULSE = 3'd0,
      CSR_SETTLE        = 3'd1,
      CSR_SELECT_SETUP  = 3'd2,
      CSR_STROBE_LOW    = 3'd3,
      CSR_STROBE_HIGH   = 3'd4,
      CSR_OVERSAMPLE    = 3'd5
   } csr_index_type;

   typedef enum logic [6:0] {
      PH_IDLE      = 7'b0000001,
      PH_CONVERT   = 7'b0000010,
      PH_SETTLE    = 7'b0000100,
      PH_WAIT_BUSY = 7'b0001000,
      PH_SETUP     = 7'b0010000,
      PH_STB_LOW   = 7'b0100000,
      PH_STB_HIGH  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic              start_request;
      logic              busy_pin;
      logic [DATA_W-1:0] data_bus;
   } req_type;

   typedef struct packed {
      logic                     convert_level;
      logic                     select_level;
      logic                     strobe_level;
      logic [OS_W-1:0]          oversample_pins;
      logic                     sample_valid;
      logic [CH_W-1:0]          channel_index;
      logic signed [DATA_W-1:0] sample_value;
      logic                     last_channel;
      logic                     sequencer_busy;
   } rsp_type;

endpackage

// File: sv/adc_parallel_read_sequencer_unit.sv
// Parallel-bus readout sequencer for a multichannel simultaneous-sampling ADC.
// Each req item is one tick of pin sampling: start request, busy pin and the
// data bus. Each accepted item produces exactly one rsp item holding the pin
// levels to drive for that tick and, on a capture tick, a signed sample with
// its channel number and a last-channel mark.
// A start request in idle pulses convert low, waits the settle time, waits
// for busy to fall, lowers chip select and strobes out every channel.
// The single result register makes rsp valid in the cycle after req
// acceptance, and one item is taken every cycle while the result is not stalled.
// If rsp_ready is low, the result register holds and req_ready drops until
// the waiting item is taken. The csr port writes the timing registers and is
// always ready; a write of code 7 to the oversampling register is ignored.
// Synchronous reset returns the sequencer to idle, empties the result
// register and restores the register defaults.
`include "adc_parallel_read_sequencer_unit_macros.svh"

module adc_parallel_read_sequencer_unit
   import aprs_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data
);

   localparam int              SHIFT   = DATA_W - SAMPLE_BITS;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

   logic [TICK_W-1:0] convert_ticks_ff, settle_ticks_ff, setup_ticks_ff;
   logic [TICK_W-1:0] strobe_low_ff, strobe_high_ff;
   logic [OS_W-1:0]   os_code_ff;

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] phase_ticks_ff, phase_ticks_in;
   logic [CH_W-1:0]   channel_count_ff, channel_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic [TICK_W-1:0]        tick_next, tick_limit;
   logic                     tick_done;
   logic signed [DATA_W-1:0] bus_aligned, sample_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign bus_aligned = signed'(req_data.data_bus << SHIFT);
   assign sample_ext  = bus_aligned >>> SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         convert_ticks_ff <= TICK_W'(4);
         settle_ticks_ff  <= TICK_W'(2);
         setup_ticks_ff   <= TICK_W'(2);
         strobe_low_ff    <= TICK_W'(2);
         strobe_high_ff   <= TICK_W'(2);
         os_code_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CONVERT_PULSE: convert_ticks_ff <= csr_data;
            CSR_SETTLE:        settle_ticks_ff  <= csr_data;
            CSR_SELECT_SETUP:  setup_ticks_ff   <= csr_data;
            CSR_STROBE_LOW:    strobe_low_ff    <= csr_data;
            CSR_STROBE_HIGH:   strobe_high_ff   <= csr_data;
            CSR_OVERSAMPLE: begin
               if (csr_data[OS_W-1:0] != OS_CODE_INVALID) begin
                  os_code_ff <= csr_data[OS_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_CONVERT:  tick_limit = convert_ticks_ff;
         PH_SETTLE:   tick_limit = settle_ticks_ff;
         PH_SETUP:    tick_limit = setup_ticks_ff;
         PH_STB_LOW:  tick_limit = strobe_low_ff;
         PH_STB_HIGH: tick_limit = strobe_high_ff;
         default:     tick_limit = '0;
      endcase
      tick_next = phase_ticks_ff + TICK_W'(1);
      tick_done = (tick_next >= tick_limit) || (tick_next == '0);
   end

   always_comb begin
      phase_in         = phase_ff;
      phase_ticks_in   = tick_done ? '0 : tick_next;
      channel_count_in = channel_count_ff;

      rsp_data_in                 = '0;
      rsp_data_in.convert_level   = 1'b1;
      rsp_data_in.select_level    = 1'b1;
      rsp_data_in.strobe_level    = 1'b1;
      rsp_data_in.oversample_pins = os_code_ff;
      rsp_data_in.sequencer_busy  = (phase_ff != PH_IDLE);

      unique case (phase_ff)
         PH_CONVERT: begin
            rsp_data_in.convert_level = 1'b0;
            if (tick_done) begin
               phase_in = PH_SETTLE;
            end
         end
         PH_SETTLE: begin
            if (tick_done) begin
               phase_in = PH_WAIT_BUSY;
            end
         end
         PH_WAIT_BUSY: begin
            phase_ticks_in = phase_ticks_ff;
            if (!req_data.busy_pin) begin
               phase_in         = PH_SETUP;
               phase_ticks_in   = '0;
               channel_count_in = '0;
            end
         end
         PH_SETUP: begin
            rsp_data_in.select_level = 1'b0;
            if (tick_done) begin
               phase_in = PH_STB_LOW;
            end
         end
         PH_STB_LOW: begin
            rsp_data_in.select_level = 1'b0;
            rsp_data_in.strobe_level = 1'b0;
            if (tick_done) begin
               phase_in = PH_STB_HIGH;
            end
         end
         PH_STB_HIGH: begin
            rsp_data_in.select_level = 1'b0;
            if (tick_done) begin
               rsp_data_in.sample_valid  = 1'b1;
               rsp_data_in.channel_index = channel_count_ff;
               rsp_data_in.sample_value  = sample_ext;
               if (channel_count_ff == LAST_CH) begin
                  rsp_data_in.last_channel = 1'b1;
                  channel_count_in         = '0;
                  phase_in                 = PH_IDLE;
               end else begin
                  channel_count_in = channel_count_ff + CH_W'(1);
                  phase_in         = PH_STB_LOW;
               end
            end
         end
         PH_IDLE: begin
            phase_ticks_in   = '0;
            channel_count_in = '0;
            if (req_data.start_request) begin
               phase_in = PH_CONVERT;
            end
         end
         default: begin
            phase_ticks_in   = '0;
            channel_count_in = '0;
            phase_in         = req_data.start_request ? PH_CONVERT : PH_IDLE;
         end
      endcase

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         phase_ticks_ff   <= '0;
         channel_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff         <= phase_in;
            phase_ticks_ff   <= phase_ticks_in;
            channel_count_ff <= channel_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `APRS_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready, "result register would be overwritten while stalled")
   `APRS_ASSERT_SAME(a_capture_pins, clock, reset, rsp_valid && rsp_data.sample_valid, !rsp_data.select_level && rsp_data.strobe_level, "sample given outside the strobe high phase")
   `APRS_ASSERT_SAME(a_last_chan, clock, reset, rsp_valid && rsp_data.last_channel, rsp_data.sample_valid && (rsp_data.channel_index == LAST_CH), "last channel mark on a wrong sample")
   `APRS_ASSERT_NEXT(a_start, clock, reset, accept && (phase_ff == PH_IDLE) && req_data.start_request, phase_ff == PH_CONVERT, "start request in idle did not begin the convert pulse")

endmodule

// File: test/sequencer_pin_checker.sv
module sequencer_pin_checker
   import aprs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data,
   output int                   mismatch_count,
   output int                   pins_pending,
   output logic                 sequencer_idle
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CHANNELS = 8;

   logic [TICK_W-1:0] convert_ticks;
   logic [TICK_W-1:0] settle_ticks;
   logic [TICK_W-1:0] setup_ticks;
   logic [TICK_W-1:0] low_ticks;
   logic [TICK_W-1:0] high_ticks;
   logic [OS_W-1:0]   os_code;

   phase_type         phase;
   logic [TICK_W-1:0] phase_ticks;
   logic [CH_W-1:0]   channel;

   rsp_type expected_pins[$];

   assign sequencer_idle = (phase == PH_IDLE);

   // A limit of zero behaves like a limit of one, and the counter wraps at ten bits.
   function automatic bit phase_done(logic [TICK_W-1:0] limit);
      logic [TICK_W-1:0] next_count;
      next_count = phase_ticks + 1'b1;
      if (next_count >= limit || next_count == '0) begin
         phase_ticks = '0;
         return 1'b1;
      end
      phase_ticks = next_count;
      return 1'b0;
   endfunction

   function automatic rsp_type advance_sequencer(req_type item);
      rsp_type pins;
      pins = '0;
      pins.convert_level = 1'b1;
      pins.select_level = 1'b1;
      pins.strobe_level = 1'b1;
      pins.oversample_pins = os_code;
      pins.sequencer_busy = (phase != PH_IDLE);
      case (phase)
         PH_CONVERT: begin
            pins.convert_level = 1'b0;
            if (phase_done(convert_ticks)) phase = PH_SETTLE;
         end
         PH_SETTLE: begin
            if (phase_done(settle_ticks)) phase = PH_WAIT_BUSY;
         end
         PH_WAIT_BUSY: begin
            if (!item.busy_pin) begin
               phase = PH_SETUP;
               phase_ticks = '0;
               channel = '0;
            end
         end
         PH_SETUP: begin
            pins.select_level = 1'b0;
            if (phase_done(setup_ticks)) phase = PH_STB_LOW;
         end
         PH_STB_LOW: begin
            pins.select_level = 1'b0;
            pins.strobe_level = 1'b0;
            if (phase_done(low_ticks)) phase = PH_STB_HIGH;
         end
         PH_STB_HIGH: begin
            pins.select_level = 1'b0;
            if (phase_done(high_ticks)) begin
               pins.sample_valid = 1'b1;
               pins.channel_index = channel;
               pins.sample_value = item.data_bus;
               if (channel == CH_W'(NUM_CHANNELS - 1)) begin
                  pins.last_channel = 1'b1;
                  channel = '0;
                  phase = PH_IDLE;
               end else begin
                  channel = channel + 1'b1;
                  phase = PH_STB_LOW;
               end
            end
         end
         default: begin
            phase = PH_IDLE;
            phase_ticks = '0;
            channel = '0;
            if (item.start_request) phase = PH_CONVERT;
         end
      endcase
      return pins;
   endfunction

   function automatic void check_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         convert_ticks = 10'd4;
         settle_ticks = 10'd2;
         setup_ticks = 10'd2;
         low_ticks = 10'd2;
         high_ticks = 10'd2;
         os_code = '0;
         phase = PH_IDLE;
         phase_ticks = '0;
         channel = '0;
         expected_pins.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pins.size() == 0) begin
               $error("rsp item arrived with no expected item waiting");
               mismatch_count++;
            end else begin
               want = expected_pins.pop_front();
               check_field("convert_level", want.convert_level, rsp_data.convert_level);
               check_field("select_level", want.select_level, rsp_data.select_level);
               check_field("strobe_level", want.strobe_level, rsp_data.strobe_level);
               check_field("oversample_pins", want.oversample_pins,
                           rsp_data.oversample_pins);
               check_field("sample_valid", want.sample_valid, rsp_data.sample_valid);
               check_field("channel_index", want.channel_index, rsp_data.channel_index);
               check_field("sample_value", want.sample_value, rsp_data.sample_value);
               check_field("last_channel", want.last_channel, rsp_data.last_channel);
               check_field("sequencer_busy", want.sequencer_busy, rsp_data.sequencer_busy);
            end
         end
         if (req_valid && req_ready) expected_pins.push_back(advance_sequencer(req_data));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CONVERT_PULSE: convert_ticks = csr_data;
               CSR_SETTLE:        settle_ticks = csr_data;
               CSR_SELECT_SETUP:  setup_ticks = csr_data;
               CSR_STROBE_LOW:    low_ticks = csr_data;
               CSR_STROBE_HIGH:   high_ticks = csr_data;
               CSR_OVERSAMPLE: begin
                  if (csr_data[OS_W-1:0] != OS_CODE_INVALID) os_code = csr_data[OS_W-1:0];
               end
               default: ;
            endcase
         end
      end
      pins_pending = expected_pins.size();
   end

endmodule

// File: test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import aprs_pkg::*;

   localparam int LONG_HOLD = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TICK_W-1:0]    csr_data;

   int   mismatch_count;
   int   pins_pending;
   logic sequencer_idle;

   bit gaps_on = 1'b1;
   int hold_asks;
   int holds_done;
   int busy_left;

   adc_parallel_read_sequencer_unit u_dut (.*);

   sequencer_pin_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Most conversions finish quickly; a few keep busy high for a long stretch.
   function automatic int pick_busy();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(0, 12);
      if (roll < 97) return $urandom_range(20, 80);
      return $urandom_range(200, 400);
   endfunction

   task automatic offer(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      wait (pins_pending == 0);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [TICK_W-1:0] value);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_timing(input int unsigned convert, input int unsigned settle,
                                 input int unsigned setup, input int unsigned strobe_low,
                                 input int unsigned strobe_high, input int unsigned oversample);
      wait_results();
      write_reg(CSR_CONVERT_PULSE, TICK_W'(convert));
      write_reg(CSR_SETTLE, TICK_W'(settle));
      write_reg(CSR_SELECT_SETUP, TICK_W'(setup));
      write_reg(CSR_STROBE_LOW, TICK_W'(strobe_low));
      write_reg(CSR_STROBE_HIGH, TICK_W'(strobe_high));
      write_reg(CSR_OVERSAMPLE, TICK_W'(oversample));
      csr_valid <= 1'b0;
   endtask

   // Well-formed frames with a converter that drops busy after a while; noisy items
   // scramble start and busy.
   task automatic run_ticks(input int count, input int noise_pct);
      req_type item;
      bit      noisy;
      repeat (count) begin
         noisy = ($urandom_range(0, 99) < noise_pct);
         item.data_bus = DATA_W'($urandom);
         if (sequencer_idle) begin
            item.start_request = noisy ? 1'($urandom) : 1'b1;
            if (item.start_request) busy_left = pick_busy();
         end else begin
            item.start_request = noisy ? 1'($urandom) : 1'b0;
         end
         item.busy_pin = (busy_left > 0) ? 1'b1 : (noisy ? 1'($urandom) : 1'b0);
         if (busy_left > 0) busy_left--;
         offer(item);
      end
   endtask

   task automatic drain();
      while (!sequencer_idle) run_ticks(1, 0);
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != holds_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            holds_done++;
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      req_type item;
      int      k;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero counts act as one; the invalid oversampling code and spare indexes are ignored.
      program_timing(0, 0, 0, 0, 0, 6);
      wait_results();
      write_reg(CSR_OVERSAMPLE, TICK_W'(OS_CODE_INVALID));
      write_reg(CSR_SPARE_LO, TICK_W'($urandom));
      write_reg(CSR_SPARE_HI, '1);
      csr_valid <= 1'b0;

      // Start stays high through the whole frame, so it is also seen while running.
      k = 0;
      do begin
         item.start_request = 1'b1;
         item.busy_pin = (k < 4);
         case (k % 5)
            0: item.data_bus = 16'h0000;
            1: item.data_bus = 16'hFFFF;
            2: item.data_bus = 16'h8000;
            3: item.data_bus = 16'h7FFF;
            default: item.data_bus = 16'h0001;
         endcase
         offer(item);
         k++;
      end while (!sequencer_idle);

      program_timing(4, 2, 2, 2, 2, 3);
      run_ticks(100, 10);

      program_timing(1, 1, 1, 1, 1, 0);
      gaps_on = 1'b0;
      run_ticks(100, 5);
      gaps_on = 1'b1;

      repeat (3) begin
         program_timing($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 8),
                        $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 1023));
         run_ticks(50, 20);
      end

      program_timing(3, 2, 1, 2, 3, 4);
      hold_asks++;
      run_ticks(100, 10);

      program_timing(12, 8, 6, 3, 3, 2);
      gaps_on = 1'b0;
      drain();
      run_ticks(1, 0);
      drain();
      gaps_on = 1'b1;

      program_timing(2, 5, 1, 3, 1, 1);
      run_ticks(60, 30);

      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: adc_parallel_read_sequencer_unit.f
+incdir+sv
sv/aprs_pkg.sv
sv/adc_parallel_read_sequencer_unit.sv
test/sequencer_pin_checker.sv
test/tb_top.sv
